// ===== sv/pdc_pkg.sv =====
// ----------------------------------------------------------------------------
// pdc_pkg
// Shared widths, reset values and register indexes of the PID controller
// with deadband, integral clamp and output limit.
// ----------------------------------------------------------------------------
package pdc_pkg;

   // defaults for the top level parameters
   localparam int SAMPLE_WIDTH_DEFAULT       = 24;
   localparam int GAIN_FRACTION_BITS_DEFAULT = 16;

   // fixed field and register widths
   localparam int GAIN_WIDTH      = 20;
   localparam int DEADBAND_WIDTH  = 23;
   localparam int INT_LIMIT_WIDTH = 23;
   localparam int OUT_LIMIT_WIDTH = 31;
   localparam int SUM_WIDTH       = 24;
   localparam int DRIVE_WIDTH     = 32;
   localparam int CSR_INDEX_WIDTH = 3;

   // register reset values
   localparam logic [GAIN_WIDTH-1:0]      GAIN_P_RESET    = GAIN_WIDTH'(262144);
   localparam logic [GAIN_WIDTH-1:0]      GAIN_I_RESET    = GAIN_WIDTH'(655);
   localparam logic [GAIN_WIDTH-1:0]      GAIN_D_RESET    = GAIN_WIDTH'(0);
   localparam logic [DEADBAND_WIDTH-1:0]  DEADBAND_RESET  = DEADBAND_WIDTH'(1);
   localparam logic [INT_LIMIT_WIDTH-1:0] INT_LIMIT_RESET = INT_LIMIT_WIDTH'(50000);
   localparam logic [OUT_LIMIT_WIDTH-1:0] OUT_LIMIT_RESET = OUT_LIMIT_WIDTH'(350);

   // register map
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_TARGET          = 3'd0,
      CSR_GAIN_P          = 3'd1,
      CSR_GAIN_I          = 3'd2,
      CSR_GAIN_D          = 3'd3,
      CSR_DEADBAND        = 3'd4,
      CSR_INTEGRAL_LIMIT  = 3'd5,
      CSR_OUTPUT_LIMIT    = 3'd6,
      CSR_OUTPUT_CLAMP_ON = 3'd7
   } csr_index_type;

endpackage

// ===== sv/pid_controller_deadband_clamp_core.sv =====
// ----------------------------------------------------------------------------
// pid_controller_deadband_clamp_core
// Positional PID controller: deadband on the error, clamped integral,
// Q4.16 gains, 32-bit saturation and an optional symmetric output limit.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                payload
//  req_      in         req_valid / req_ready    req_measured
//  rsp_      out        rsp_valid / rsp_ready    rsp_drive, rsp_limited
//  csr_      in         csr_write_enable         csr_index, csr_data
//
//  A request is held in the input register and then computed into the result
//  register once that is free: one request per cycle while rsp_ready is high.
//  The rate is set by the error / integral update, done in one pass per cycle.
//  When rsp_ready is low the input register still takes one more request.
//  Reset is synchronous; it empties both registers and restores all settings,
//  the integral and the previous error.
//
module pid_controller_deadband_clamp_core #(
   parameter int  SAMPLE_WIDTH       = pdc_pkg::SAMPLE_WIDTH_DEFAULT,
   parameter int  GAIN_FRACTION_BITS = pdc_pkg::GAIN_FRACTION_BITS_DEFAULT,
   localparam int CSR_DATA_WIDTH     =
      (SAMPLE_WIDTH > pdc_pkg::OUT_LIMIT_WIDTH) ? SAMPLE_WIDTH : pdc_pkg::OUT_LIMIT_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]        req_measured,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [pdc_pkg::DRIVE_WIDTH-1:0] rsp_drive,
   output logic                                  rsp_limited,
   input  logic                                  csr_write_enable,
   input  logic [pdc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]             csr_data
);

   localparam int GW  = pdc_pkg::GAIN_WIDTH;
   localparam int SUW = pdc_pkg::SUM_WIDTH;
   localparam int OW  = pdc_pkg::DRIVE_WIDTH;
   localparam int LW  = pdc_pkg::OUT_LIMIT_WIDTH;
   localparam int EW  = SAMPLE_WIDTH + 1;
   localparam int DW  = (EW > pdc_pkg::DEADBAND_WIDTH) ? EW : pdc_pkg::DEADBAND_WIDTH;
   localparam int SW  = ((SUW > EW) ? SUW : EW) + 1;
   localparam int FW  = EW + 1;
   localparam int PPW = GW + 1 + EW;
   localparam int PIW = GW + 1 + SUW;
   localparam int PDW = GW + 1 + FW;
   localparam int AW  = ((PDW > PIW) ? PDW : PIW) + 2;
   localparam int XW  = (AW > OW + 2) ? AW : OW + 2;

   localparam logic signed [XW-1:0] DRIVE_MAX = {{(XW-OW+1){1'b0}}, {(OW-1){1'b1}}};
   localparam logic signed [XW-1:0] DRIVE_MIN = {{(XW-OW+1){1'b1}}, {(OW-1){1'b0}}};

   // settings
   logic signed [SAMPLE_WIDTH-1:0]           target_ff;
   logic [GW-1:0]                            gain_p_ff, gain_i_ff, gain_d_ff;
   logic [pdc_pkg::DEADBAND_WIDTH-1:0]       deadband_ff;
   logic [pdc_pkg::INT_LIMIT_WIDTH-1:0]      integral_limit_ff;
   logic [LW-1:0]                            output_limit_ff;
   logic                                     output_clamp_on_ff;

   // controller state
   logic signed [SUW-1:0] error_sum_ff, error_sum_in;
   logic signed [EW-1:0]  previous_error_ff, previous_error_in;

   // input and result registers
   logic                           in_valid_ff, in_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] measured_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [OW-1:0]           drive_ff, drive_in;
   logic                           limited_ff, limited_in;

   logic req_fire, load_rsp, advance;

   // datapath
   logic signed [EW-1:0]  err_raw, err_db;
   logic [EW-1:0]         err_mag;
   logic signed [SW-1:0]  sum_raw, sum_limit, sum_clamped;
   logic signed [FW-1:0]  err_diff;
   logic signed [PPW-1:0] prod_p;
   logic signed [PIW-1:0] prod_i;
   logic signed [PDW-1:0] prod_d;
   logic signed [AW-1:0]  acc, acc_shifted;
   logic signed [XW-1:0]  y_wide, y_sat;
   logic                  sat_hit, clamp_hit;
   logic signed [OW:0]    y_ext, out_lim_pos, out_lim_neg, y_final;

   assign load_rsp  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && load_rsp;
   assign req_ready = !in_valid_ff || load_rsp;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      err_raw = EW'(target_ff) - EW'(measured_ff);
      err_mag = err_raw[EW-1] ? unsigned'(-err_raw) : unsigned'(err_raw);
      if (DW'(err_mag) < DW'(deadband_ff)) begin
         err_db = '0;
      end else begin
         err_db = err_raw;
      end

      sum_raw   = SW'(error_sum_ff) + SW'(err_db);
      sum_limit = signed'(SW'(integral_limit_ff));
      priority if (sum_raw >= sum_limit) begin
         sum_clamped = sum_limit;
      end else if (sum_raw < -sum_limit) begin
         sum_clamped = -sum_limit;
      end else begin
         sum_clamped = sum_raw;
      end

      err_diff = FW'(err_db) - FW'(previous_error_ff);
      prod_p   = signed'({1'b0, gain_p_ff}) * err_db;
      prod_i   = signed'({1'b0, gain_i_ff}) * SUW'(sum_clamped);
      prod_d   = signed'({1'b0, gain_d_ff}) * err_diff;
      acc      = AW'(prod_p) + AW'(prod_i) + AW'(prod_d);

      // arithmetic shift rounds toward minus infinity
      acc_shifted = acc >>> GAIN_FRACTION_BITS;
      y_wide      = XW'(acc_shifted);
      priority if (y_wide > DRIVE_MAX) begin
         y_sat   = DRIVE_MAX;
         sat_hit = 1'b1;
      end else if (y_wide < DRIVE_MIN) begin
         y_sat   = DRIVE_MIN;
         sat_hit = 1'b1;
      end else begin
         y_sat   = y_wide;
         sat_hit = 1'b0;
      end

      y_ext       = (OW+1)'(signed'(y_sat[OW-1:0]));
      out_lim_pos = signed'({2'b00, output_limit_ff});
      out_lim_neg = -out_lim_pos;
      clamp_hit   = 1'b0;
      y_final     = y_ext;
      if (output_clamp_on_ff) begin
         priority if (y_ext > out_lim_pos) begin
            y_final   = out_lim_pos;
            clamp_hit = 1'b1;
         end else if (y_ext < out_lim_neg) begin
            y_final   = out_lim_neg;
            clamp_hit = 1'b1;
         end else begin
            y_final   = y_ext;
         end
      end

      drive_in          = y_final[OW-1:0];
      limited_in        = sat_hit || clamp_hit;
      error_sum_in      = sum_clamped[SUW-1:0];
      previous_error_in = err_db;
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = load_rsp ? in_valid_ff : rsp_valid_ff;
   end

   // control, settings and state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         target_ff          <= '0;
         gain_p_ff          <= pdc_pkg::GAIN_P_RESET;
         gain_i_ff          <= pdc_pkg::GAIN_I_RESET;
         gain_d_ff          <= pdc_pkg::GAIN_D_RESET;
         deadband_ff        <= pdc_pkg::DEADBAND_RESET;
         integral_limit_ff  <= pdc_pkg::INT_LIMIT_RESET;
         output_limit_ff    <= pdc_pkg::OUT_LIMIT_RESET;
         output_clamp_on_ff <= 1'b0;
         error_sum_ff       <= '0;
         previous_error_ff  <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            error_sum_ff      <= error_sum_in;
            previous_error_ff <= previous_error_in;
         end
         if (csr_write_enable) begin
            unique case (pdc_pkg::csr_index_type'(csr_index))
               pdc_pkg::CSR_TARGET:          target_ff <= signed'(csr_data[SAMPLE_WIDTH-1:0]);
               pdc_pkg::CSR_GAIN_P:          gain_p_ff <= csr_data[GW-1:0];
               pdc_pkg::CSR_GAIN_I:          gain_i_ff <= csr_data[GW-1:0];
               pdc_pkg::CSR_GAIN_D:          gain_d_ff <= csr_data[GW-1:0];
               pdc_pkg::CSR_DEADBAND:
                  deadband_ff <= csr_data[pdc_pkg::DEADBAND_WIDTH-1:0];
               pdc_pkg::CSR_INTEGRAL_LIMIT:
                  integral_limit_ff <= csr_data[pdc_pkg::INT_LIMIT_WIDTH-1:0];
               pdc_pkg::CSR_OUTPUT_LIMIT:    output_limit_ff <= csr_data[LW-1:0];
               pdc_pkg::CSR_OUTPUT_CLAMP_ON: output_clamp_on_ff <= csr_data[0];
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         measured_ff <= req_measured;
      end
      if (advance) begin
         drive_ff   <= drive_in;
         limited_ff <= limited_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_drive   = drive_ff;
   assign rsp_limited = limited_ff;

endmodule

// ===== sv/pdc_checker.sv =====
// ----------------------------------------------------------------------------
// pdc_checker
// Port-level checks of the PID controller core, attached by bind.
// ----------------------------------------------------------------------------
module pdc_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_ready,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic signed [pdc_pkg::DRIVE_WIDTH-1:0] rsp_drive,
   input logic                                   rsp_limited
);

   // a stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive) && $stable(rsp_limited))
      else $error("result changed while stalled");

   // reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // with no result waiting the block always takes a request
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request refused with empty result register");

   // only one request is buffered behind a stalled result
   a_one_buffered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready && $past(rsp_valid && !rsp_ready)
         && $past(req_valid && req_ready) && !$past(reset) |-> !req_ready)
      else $error("request taken with full input register");

endmodule

bind pid_controller_deadband_clamp_core pdc_checker u_pdc_checker (.*);
